// ===== src/crcfc_pkg.sv =====
// Shared types, codes and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies; compile first.
package crcfc_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [15:0] COUNT_WRAP = 16'hFFFF;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIQUE_ID    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUNCTION_ID  = 2'd2;

   localparam logic [8:0] FRAME_LENGTH_RESET = 9'd64;
   localparam int         MIN_FRAME_BYTES    = 4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_ID_ERR  = 2'd2
   } status_type;

   // Reflected CRC-16 update over one byte, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== src/crcfc_ifs.sv =====
// Valid/ready channel interfaces for the frame checker's byte input and result output.
// No dependencies on other files.
interface crcfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface crcfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] good_frame_count;
   logic [15:0] computed_crc;

   modport source (output valid, output status, output good_frame_count,
                   output computed_crc, input ready);
   modport sink   (input valid, input status, input good_frame_count,
                   input computed_crc, output ready);
endinterface

// ===== src/crc16_frame_checker.sv =====
// A frame's result is registered and valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the CRC update is a byte-wide XOR network.
// A last byte stalls only while the previous result is still held and not taken.
// Reset (synchronous, active high): frame_length 64, IDs 0, CRC 0xFFFF,
// position 0, good-frame count 0, result register empty.
// Top level of the CRC-16/MODBUS frame checker; depends on crcfc_pkg, crcfc_ifs.
module crc16_frame_checker #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   crcfc_req_if.sink                              req_chan,
   crcfc_rsp_if.source                            rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [crcfc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [crcfc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int CMP_W = ((LEN_W > 9) ? LEN_W : 9) + 1;

   localparam logic [CMP_W-1:0] MIN_LEN = CMP_W'(crcfc_pkg::MIN_FRAME_BYTES);
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME_BYTES);

   logic [8:0]       frame_length_ff;
   logic [7:0]       unique_id_ff;
   logic [7:0]       function_id_ff;
   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ids_ok_ff, ids_ok_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [15:0]      good_ff, good_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [15:0]      count_ff;
   logic [15:0]      ccrc_ff;

   logic [CMP_W-1:0] fl_ext, eff_len, pos_ext;
   logic             is_last, is_crc_lo, req_take, rsp_take;
   logic [15:0]      received, good_inc;

   always_comb begin
      fl_ext = CMP_W'(frame_length_ff);
      priority if (fl_ext < MIN_LEN) begin
         eff_len = MIN_LEN;
      end else if (fl_ext > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = fl_ext;
      end
   end

   assign pos_ext   = CMP_W'(pos_ff);
   assign is_last   = !((pos_ext + CMP_W'(1)) < eff_len);
   assign is_crc_lo = (pos_ext + CMP_W'(2)) == eff_len;

   // A non-final byte produces nothing, so only the final byte waits on the result slot.
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !is_last || !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign received = {req_chan.data_byte, crc_lo_ff};
   assign good_inc = good_ff + 16'd1;

   always_comb begin
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      ids_ok_in    = ids_ok_ff;
      crc_lo_in    = crc_lo_ff;
      good_in      = good_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      status_in    = crcfc_pkg::STATUS_OK;
      if (req_take) begin
         if (!is_last) begin
            pos_in = pos_ff + POS_W'(1);
            if (is_crc_lo) begin
               crc_lo_in = req_chan.data_byte;
            end else begin
               if (pos_ff == POS_W'(0) && req_chan.data_byte != unique_id_ff) begin
                  ids_ok_in = 1'b0;
               end
               if (pos_ff == POS_W'(1) && req_chan.data_byte != function_id_ff) begin
                  ids_ok_in = 1'b0;
               end
               crc_in = crcfc_pkg::crc_byte(crc_ff, req_chan.data_byte);
            end
         end else begin
            rsp_valid_in = 1'b1;
            if (received != crc_ff) begin
               status_in = crcfc_pkg::STATUS_CRC_ERR;
            end else begin
               good_in   = (good_inc == crcfc_pkg::COUNT_WRAP) ? 16'd0 : good_inc;
               status_in = ids_ok_ff ? crcfc_pkg::STATUS_OK : crcfc_pkg::STATUS_ID_ERR;
            end
            // rearm for the next frame
            crc_in    = crcfc_pkg::CRC_INIT;
            pos_in    = '0;
            ids_ok_in = 1'b1;
            crc_lo_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= crcfc_pkg::FRAME_LENGTH_RESET;
         unique_id_ff    <= 8'd0;
         function_id_ff  <= 8'd0;
         crc_ff          <= crcfc_pkg::CRC_INIT;
         pos_ff          <= '0;
         ids_ok_ff       <= 1'b1;
         crc_lo_ff       <= 8'd0;
         good_ff         <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         ids_ok_ff    <= ids_ok_in;
         crc_lo_ff    <= crc_lo_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               crcfc_pkg::CSR_FRAME_LENGTH: frame_length_ff <= csr_write_data;
               crcfc_pkg::CSR_UNIQUE_ID:    unique_id_ff    <= csr_write_data[7:0];
               crcfc_pkg::CSR_FUNCTION_ID:  function_id_ff  <= csr_write_data[7:0];
               default: ;
            endcase
         end
      end
   end

   // Result payload: load on the transaction of a frame's final byte.
   always_ff @(posedge clock) begin
      if (req_take && is_last) begin
         status_ff <= status_in;
         count_ff  <= good_in;
         ccrc_ff   <= crc_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.good_frame_count = count_ff;
   assign rsp_chan.computed_crc     = ccrc_ff;

endmodule

// ===== src/crcfc_checker.sv =====
// Port-level assertions for crc16_frame_checker, attached with a bind.
// Depends on crcfc_pkg and the top level's channel interfaces.
module crcfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_good_frame_count,
   input logic [15:0] rsp_computed_crc
);

   // No result survives reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only the three defined status codes are ever shown.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == crcfc_pkg::STATUS_OK
                  || rsp_status == crcfc_pkg::STATUS_CRC_ERR
                  || rsp_status == crcfc_pkg::STATUS_ID_ERR))
      else $error("undefined status code");

   // The good-frame count wraps before reaching all ones.
   a_count_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_good_frame_count != crcfc_pkg::COUNT_WRAP)
      else $error("good-frame count reached wrap value");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_good_frame_count)
                                  && $stable(rsp_computed_crc))
      else $error("result payload changed while stalled");

endmodule

bind crc16_frame_checker crcfc_checker u_crcfc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_status           (rsp_chan.status),
   .rsp_good_frame_count (rsp_chan.good_frame_count),
   .rsp_computed_crc     (rsp_chan.computed_crc)
);
